// ===== rtl/lpe_pkg.sv =====
package lpe_pkg;

    // Widths fixed by the item fields.
    localparam int READING_W = 16;
    localparam int REG_W     = 16;
    localparam int POS_W     = 12;

    // Default number of significant bits in one reading.
    localparam int SAMPLE_BITS_DEF = 16;

    // The quotient always lies in 1000..3000, so twelve bits hold it.
    localparam int QUO_W     = 12;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = 4;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_THR  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_THR = CFG_IDX_W'(1);

    localparam logic [REG_W-1:0] LINE_THR_RST  = REG_W'(200);
    localparam logic [REG_W-1:0] NOISE_THR_RST = REG_W'(50);

    // Position constants.
    localparam int WEIGHT_STEP = 1000;
    localparam logic [POS_W-1:0] CENTER_POS = POS_W'(2000);
    localparam logic [POS_W-1:0] FAR_LEFT   = POS_W'(0);
    localparam logic [POS_W-1:0] FAR_RIGHT  = POS_W'(4000);

    typedef struct packed {
        logic [READING_W-1:0] sensor_left;
        logic [READING_W-1:0] sensor_center;
        logic [READING_W-1:0] sensor_right;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             line_seen;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_lpe_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic finish;
    } t_lpe_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic out_free;
    } t_lpe_status;

endpackage

// ===== rtl/lpe_ctrl.sv =====
module lpe_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lpe_pkg::t_lpe_status i_status,
    output lpe_pkg::t_lpe_cmd    o_cmd
);

    lpe_pkg::t_lpe_state             r_state, n_state;
    logic [lpe_pkg::CNT_W-1:0]       r_cnt, n_cnt;

    // State and step counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpe_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands. The input side stays closed while reset is held.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            lpe_pkg::ST_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = lpe_pkg::ST_MUL;
                end
            end
            lpe_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = i_status.need_div ? lpe_pkg::ST_DIV : lpe_pkg::ST_DONE;
            end
            lpe_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == lpe_pkg::CNT_W'(lpe_pkg::DIV_STEPS - 1)) begin
                    n_state = lpe_pkg::ST_DONE;
                end
            end
            lpe_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = lpe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lpe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/lpe_datapath.sv =====
module lpe_datapath #(
    parameter int SAMPLE_BITS = lpe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lpe_pkg::t_lpe_cmd               i_cmd,
    output lpe_pkg::t_lpe_status            o_status,
    input  lpe_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lpe_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_valid,
    input  logic [lpe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lpe_pkg::REG_W-1:0]       i_cfg_data
);

    // Plain sum of three readings, and l + 2c + 3r.
    localparam int PLAIN_W = SAMPLE_BITS + 2;
    localparam int SCALE_W = SAMPLE_BITS + 3;
    // Weighted sum is 1000 * (l + 2c + 3r) and fits SAMPLE_BITS + 13 bits;
    // the shifted divisor plain << 11 has the same width.
    localparam int SUM_W   = SAMPLE_BITS + 13;
    localparam int QUO_W   = lpe_pkg::QUO_W;

    logic [lpe_pkg::REG_W-1:0] r_line_thr, r_noise_thr;
    logic [lpe_pkg::POS_W-1:0] r_last_pos;
    logic                      r_seen;
    logic [PLAIN_W-1:0]        r_plain;
    logic [SCALE_W-1:0]        r_scale;
    logic [SUM_W-1:0]          r_rem;
    logic [SUM_W-1:0]          r_div;
    logic [QUO_W-1:0]          r_quo;
    logic                      r_out_valid;
    lpe_pkg::t_out_item        r_out_data;

    logic [SAMPLE_BITS-1:0]    samp_l, samp_c, samp_r;
    logic [SCALE_W-1:0]        inc_l, inc_c, inc_r;
    logic                      seen;
    logic [PLAIN_W-1:0]        plain;
    logic [SCALE_W-1:0]        scale;
    logic                      ge;
    lpe_pkg::t_out_item        result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_thr  <= lpe_pkg::LINE_THR_RST;
            r_noise_thr <= lpe_pkg::NOISE_THR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lpe_pkg::REG_LINE_THR:  r_line_thr  <= i_cfg_data;
                lpe_pkg::REG_NOISE_THR: r_noise_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Threshold tests and the narrow sums on the incoming item.
    always_comb begin
        samp_l = i_in_data.sensor_left[SAMPLE_BITS-1:0];
        samp_c = i_in_data.sensor_center[SAMPLE_BITS-1:0];
        samp_r = i_in_data.sensor_right[SAMPLE_BITS-1:0];
        seen   = (lpe_pkg::REG_W'(samp_l) > r_line_thr)
               | (lpe_pkg::REG_W'(samp_c) > r_line_thr)
               | (lpe_pkg::REG_W'(samp_r) > r_line_thr);
        inc_l  = (lpe_pkg::REG_W'(samp_l) > r_noise_thr) ? SCALE_W'(samp_l) : '0;
        inc_c  = (lpe_pkg::REG_W'(samp_c) > r_noise_thr) ? SCALE_W'(samp_c) : '0;
        inc_r  = (lpe_pkg::REG_W'(samp_r) > r_noise_thr) ? SCALE_W'(samp_r) : '0;
        plain  = PLAIN_W'(inc_l + inc_c + inc_r);
        scale  = inc_l + (inc_c << 1) + (inc_r << 1) + inc_r;
    end

    // Restoring division step: one quotient bit per cycle, MSB first.
    assign ge = (r_rem >= r_div);

    // Capture, scale by the weight step, then divide.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_seen  <= seen;
            r_plain <= plain;
            r_scale <= scale;
        end
        if (i_cmd.mul) begin
            r_rem <= SUM_W'(r_scale) * SUM_W'(lpe_pkg::WEIGHT_STEP);
            r_div <= SUM_W'({r_plain, {(QUO_W - 1){1'b0}}});
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            if (ge) begin
                r_rem <= r_rem - r_div;
            end
            r_div <= r_div >> 1;
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    // Select the result: quotient, held position, or a far edge.
    always_comb begin
        result.line_seen = r_seen;
        if (!r_seen) begin
            result.position = (r_last_pos < lpe_pkg::CENTER_POS) ?
                              lpe_pkg::FAR_LEFT : lpe_pkg::FAR_RIGHT;
        end else if (r_plain == '0) begin
            result.position = r_last_pos;
        end else begin
            result.position = lpe_pkg::POS_W'(r_quo);
        end
    end

    // Stored position follows each divided result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pos <= '0;
        end else if (i_cmd.finish && r_seen && (r_plain != '0)) begin
            r_last_pos <= lpe_pkg::POS_W'(r_quo);
        end
    end

    // Output register; it is freed by a transfer on the output channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
    assign o_status.need_div = r_seen && (r_plain != '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

// ===== rtl/line_position_estimator_unit.sv =====
// Line position estimator.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries the three middle
// reflectance readings of a sensor bar. Output channel (o_out_valid /
// i_out_ready / o_out_data) returns one position and a line-seen flag per item.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
// writes the line threshold (index 0) or the noise threshold (index 1); it is
// ready whenever reset is released, and other indexes are ignored.
// One item is processed at a time. When the line is seen and some reading is
// above noise, the position is found by a restoring divider that produces one
// quotient bit per cycle, and the block takes no new item until the division
// is done and the result is handed to the output register. Otherwise the
// divider is skipped and the result goes from the scaling step straight to
// the output register.
// The result sits in an output register; the block accepts the next item
// while it waits. A stalled receiver holds the finished item in the datapath
// with the controller waiting; no input is taken until the register is free.
// Synchronous reset restores the thresholds to 200 and 50, clears the stored
// position to 0 and empties the output register; both ready outputs stay low
// while reset is held.
module line_position_estimator_unit #(
    parameter int SAMPLE_BITS = lpe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  lpe_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lpe_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lpe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lpe_pkg::REG_W-1:0]       i_cfg_data
);

    lpe_pkg::t_lpe_cmd    cmd;
    lpe_pkg::t_lpe_status status;

    assign o_cfg_ready = i_rst_n;

    // Sequencer.
    lpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Sums, divider and output register.
    lpe_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

// ===== rtl/lpe_checker.sv =====
module lpe_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input lpe_pkg::t_out_item o_out_data
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped before transfer");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // Positions never pass the far right edge.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.position <= lpe_pkg::FAR_RIGHT)
        else $error("position out of range");

    // Without the line, the position is the far left or the far right edge.
    a_lost_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.line_seen |->
            (o_out_data.position == lpe_pkg::FAR_LEFT) ||
            (o_out_data.position == lpe_pkg::FAR_RIGHT))
        else $error("lost line gave a position off the edges");

    // One item in work at a time: an input transfer closes the input side.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in work");

endmodule

bind line_position_estimator_unit lpe_checker u_lpe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
